FILE: src/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and constants for the MIPS subset instruction step block:
// memory geometry, opcode and funct codes.
// ----------------------------------------------------------------------------
package mst_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  reg_idx_t;
  typedef logic [9:0]  mem_addr_t;
  typedef logic [5:0]  opcode_t;

  localparam int DATA_BYTES = 1024;
  localparam int MEM_ROWS   = DATA_BYTES / 4;
  localparam int ROW_W      = $clog2(MEM_ROWS);

  localparam word_t MAX_WORD_ADDR = 32'(DATA_BYTES - 4);
  localparam word_t PC_TOP_MASK   = 32'hF000_0000;

  localparam opcode_t OP_SPECIAL  = 6'b000000;
  localparam opcode_t OP_J        = 6'b000010;
  localparam opcode_t OP_BEQ      = 6'b000100;
  localparam opcode_t OP_BNE      = 6'b000101;
  localparam opcode_t OP_SPECIAL2 = 6'b011100;
  localparam opcode_t OP_LW       = 6'b100011;
  localparam opcode_t OP_SW       = 6'b101011;

  localparam opcode_t FN_MUL = 6'b000010;
  localparam opcode_t FN_ADD = 6'b100000;
  localparam opcode_t FN_SUB = 6'b100010;

endpackage

FILE: src/mst_instr_if.sv
// ----------------------------------------------------------------------------
// mst_instr_if
// Valid/ready channel that carries one instruction word per transaction.
// ----------------------------------------------------------------------------
interface mst_instr_if;
  import mst_pkg::*;

  logic  valid;
  logic  ready;
  word_t instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);

endinterface

FILE: src/mst_result_if.sv
// ----------------------------------------------------------------------------
// mst_result_if
// Valid/ready channel that carries the outcome of one executed instruction.
// ----------------------------------------------------------------------------
interface mst_result_if;
  import mst_pkg::*;

  logic      valid;
  logic      ready;
  word_t     next_pc;
  logic      branch_taken;
  logic      reg_write;
  reg_idx_t  reg_index;
  word_t     reg_value;
  logic      mem_write;
  mem_addr_t mem_addr;
  word_t     mem_data;
  logic      bad_instr;
  logic      addr_fault;

  modport source (
    output valid, output next_pc, output branch_taken, output reg_write,
    output reg_index, output reg_value, output mem_write, output mem_addr,
    output mem_data, output bad_instr, output addr_fault, input ready
  );
  modport sink (
    input valid, input next_pc, input branch_taken, input reg_write,
    input reg_index, input reg_value, input mem_write, input mem_addr,
    input mem_data, input bad_instr, input addr_fault, output ready
  );

endinterface

FILE: src/mips_subset_instruction_step.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_step
// Executes one MIPS subset instruction (lw, sw, add, sub, mul, beq, bne, j)
// per transaction against a kept PC, register file and byte data memory.
//
// Usage:
//   instr  : sink channel, one 32-bit instruction word per transaction.
//   result : source channel, one result transaction per instruction.
//   An instruction taken is held and executed in the execute stage, and its
//   result is registered into the result stage and presented from there.
//   Throughput is one instruction per cycle while result.ready is high; the
//   data memory is four byte banks with one read and one write port each,
//   so any word, aligned or not, is read or written in a single access.
//   Operands come from the register file read at acceptance, corrected by
//   forwarding from the result stage and from the write done at that edge.
//   Reset (rst, synchronous) zeroes the PC and the register file valid bits
//   and starts a clearing pass over the DATA_BYTES / 4 data memory rows
//   (256 at the default size); instr.ready stays low until it is done.
//   When result.ready is low the result stage holds, one more instruction
//   is taken into the execute stage, and then instr.ready drops.
// ----------------------------------------------------------------------------
module mips_subset_instruction_step (
  input  logic                 clk,
  input  logic                 rst,
  mst_instr_if.sink            instr,
  mst_result_if.source         result
);
  import mst_pkg::*;

  typedef struct packed {
    word_t     next_pc;
    logic      taken;
    logic      wr;
    reg_idx_t  idx;
    word_t     wval;
    logic      mw;
    mem_addr_t maddr;
    word_t     mdata;
    logic      bad;
    logic      fault;
    logic      ld;
    logic [1:0] off;
  } res_t;

  // control
  logic             s1_v;
  logic             s2_v;
  logic             clr_busy;
  logic [ROW_W-1:0] clr_row;
  logic             in_fire;
  logic             s2_free;
  logic             s2_fire;
  logic             adv1;

  // execute stage payload
  word_t s1_instr;
  word_t s1_rf_a;
  word_t s1_rf_b;
  logic  s1_vld_a;
  logic  s1_vld_b;
  logic  s1_hit_a;
  logic  s1_hit_b;
  word_t s1_byp;

  // register file
  word_t       rf [32];
  logic [31:0] rf_vld;
  logic        rf_we;

  // result stage
  res_t  s2;
  res_t  s2_next;
  word_t ld_word;
  word_t s2_wval;

  // program counter
  word_t pc;

  // execute stage decode
  opcode_t          op;
  opcode_t          fn;
  reg_idx_t         rs;
  reg_idx_t         rt;
  reg_idx_t         rd;
  word_t            simm;
  word_t            opa;
  word_t            opb;
  word_t            addr;
  word_t            pc4;
  word_t            prod;
  logic             st_do;
  logic [ROW_W-1:0] row_base;

  // data memory banks
  logic [ROW_W-1:0] bank_row [4];
  logic [7:0]       bank_wd  [4];
  logic [7:0]       bank_q   [4];
  logic             bank_we;

  assign s2_free = !s2_v || result.ready;
  assign s2_fire = s2_v && result.ready;
  assign adv1    = s1_v && s2_free;
  assign instr.ready = !clr_busy && (!s1_v || s2_free);
  assign in_fire = instr.valid && instr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      clr_busy <= 1'b1;
      clr_row  <= '0;
      pc       <= '0;
      rf_vld   <= '0;
    end else begin
      if (in_fire) begin
        s1_v <= 1'b1;
      end else if (adv1) begin
        s1_v <= 1'b0;
      end
      if (adv1) begin
        s2_v <= 1'b1;
        pc   <= s2_next.next_pc;
      end else if (s2_fire) begin
        s2_v <= 1'b0;
      end
      if (clr_busy) begin
        clr_row <= clr_row + 1'b1;
        if (clr_row == ROW_W'(MEM_ROWS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (rf_we) begin
        rf_vld[s2.idx] <= 1'b1;
      end
    end
  end

  // register file: write on retire, registered reads at acceptance
  assign rf_we = s2_fire && s2.wr;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[s2.idx] <= s2_wval;
    end
    if (in_fire) begin
      s1_rf_a <= rf[instr.instr_word[25:21]];
      s1_rf_b <= rf[instr.instr_word[20:16]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr <= instr.instr_word;
      s1_vld_a <= rf_vld[instr.instr_word[25:21]];
      s1_vld_b <= rf_vld[instr.instr_word[20:16]];
      s1_hit_a <= rf_we && (s2.idx == instr.instr_word[25:21]);
      s1_hit_b <= rf_we && (s2.idx == instr.instr_word[20:16]);
      s1_byp   <= s2_wval;
    end
    if (adv1) begin
      s2 <= s2_next;
    end
  end

  // load word assembly in the result stage
  always_comb begin
    ld_word = '0;
    for (int k = 0; k < 4; k++) begin
      ld_word[31 - 8*k -: 8] = bank_q[2'(k) + s2.off];
    end
    s2_wval = s2.ld ? (s2.wr ? ld_word : '0) : s2.wval;
  end

  // execute stage
  assign op   = s1_instr[31:26];
  assign fn   = s1_instr[5:0];
  assign rs   = s1_instr[25:21];
  assign rt   = s1_instr[20:16];
  assign rd   = s1_instr[15:11];
  assign simm = {{16{s1_instr[15]}}, s1_instr[15:0]};

  always_comb begin
    if (s2_v && s2.wr && (s2.idx == rs)) begin
      opa = s2_wval;
    end else if (s1_hit_a) begin
      opa = s1_byp;
    end else begin
      opa = s1_vld_a ? s1_rf_a : '0;
    end
    if (s2_v && s2.wr && (s2.idx == rt)) begin
      opb = s2_wval;
    end else if (s1_hit_b) begin
      opb = s1_byp;
    end else begin
      opb = s1_vld_b ? s1_rf_b : '0;
    end
  end

  assign addr     = opa + simm;
  assign pc4      = pc + 32'd4;
  assign prod     = opa * opb;
  assign row_base = addr[ROW_W+1:2];

  always_comb begin
    s2_next         = '0;
    s2_next.next_pc = pc4;
    s2_next.off     = addr[1:0];
    st_do           = 1'b0;
    unique case (op)
      OP_LW, OP_SW: begin
        s2_next.maddr = addr[9:0];
        if (addr > MAX_WORD_ADDR) begin
          s2_next.fault = 1'b1;
        end else if (op == OP_LW) begin
          s2_next.ld  = 1'b1;
          s2_next.wr  = (rt != '0);
          s2_next.idx = (rt != '0) ? rt : '0;
        end else begin
          st_do         = 1'b1;
          s2_next.mw    = 1'b1;
          s2_next.mdata = opb;
        end
      end
      OP_SPECIAL: begin
        if (fn == FN_ADD) begin
          s2_next.wval = opa + opb;
          s2_next.wr   = 1'b1;
        end else if (fn == FN_SUB) begin
          s2_next.wval = opa - opb;
          s2_next.wr   = 1'b1;
        end else begin
          s2_next.bad = 1'b1;
        end
      end
      OP_SPECIAL2: begin
        if (fn == FN_MUL) begin
          s2_next.wval = prod;
          s2_next.wr   = 1'b1;
        end else begin
          s2_next.bad = 1'b1;
        end
      end
      OP_BEQ, OP_BNE: begin
        if ((op == OP_BEQ) == (opa == opb)) begin
          s2_next.next_pc = pc4 + {simm[29:0], 2'b00};
          s2_next.taken   = 1'b1;
        end
      end
      OP_J: begin
        s2_next.next_pc = (pc4 & PC_TOP_MASK) | {4'b0000, s1_instr[25:0], 2'b00};
        s2_next.taken   = 1'b1;
      end
      default: begin
        s2_next.bad = 1'b1;
      end
    endcase
    // drop writes to register zero
    if (!s2_next.ld && (rd == '0)) begin
      s2_next.wr   = 1'b0;
      s2_next.wval = '0;
    end else if (!s2_next.ld && s2_next.wr) begin
      s2_next.idx = rd;
    end
  end

  // bank addressing: bank j holds bytes whose address is j modulo four
  always_comb begin
    logic [1:0] k;
    for (int j = 0; j < 4; j++) begin
      k = 2'(j) - addr[1:0];
      bank_row[j] = clr_busy ? clr_row
                  : row_base + ROW_W'(2'(j) < addr[1:0]);
      bank_wd[j]  = clr_busy ? 8'h00 : 8'(opb >> {3'(2'd3 - k), 3'b000});
    end
  end

  assign bank_we = clr_busy || (adv1 && st_do);

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [MEM_ROWS];

    always_ff @(posedge clk) begin
      if (bank_we) begin
        mem[bank_row[g]] <= bank_wd[g];
      end
      if (adv1) begin
        bank_q[g] <= mem[bank_row[g]];
      end
    end
  end

  assign result.valid        = s2_v;
  assign result.next_pc      = s2.next_pc;
  assign result.branch_taken = s2.taken;
  assign result.reg_write    = s2.wr;
  assign result.reg_index    = s2.idx;
  assign result.reg_value    = s2_wval;
  assign result.mem_write    = s2.mw;
  assign result.mem_addr     = s2.maddr;
  assign result.mem_data     = s2.ld ? ld_word : s2.mdata;
  assign result.bad_instr    = s2.bad;
  assign result.addr_fault   = s2.fault;

  a_pc_tracks_last : assert property (@(posedge clk) disable iff (rst)
    (s2_v && !s1_v) |-> (pc == s2.next_pc))
    else $error("pc does not match last executed instruction");

  a_r0_never_valid : assert property (@(posedge clk) disable iff (rst)
    !rf_vld[0])
    else $error("register zero marked written");

  a_no_store_in_clear : assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !(adv1 && st_do))
    else $error("store issued during memory clear");

  a_flag_no_effect : assert property (@(posedge clk) disable iff (rst)
    (s2_v && (s2.bad || s2.fault)) |-> (!s2.wr && !s2.mw))
    else $error("flagged instruction has side effects");

  a_wr_nonzero : assert property (@(posedge clk) disable iff (rst)
    (s2_v && s2.wr) |-> (s2.idx != '0))
    else $error("write aimed at register zero");

endmodule
